### design/gray_block_cmpr_encoder_defines.svh
// Assertion macros for the grey block encoder top-level design file.
`ifndef GRAY_BLOCK_CMPR_ENCODER_DEFINES_SVH
`define GRAY_BLOCK_CMPR_ENCODER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define GBCE_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define GBCE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/gbce_pkg.sv
// Types, constants and helper functions for the grey block encoder.
package gbce_pkg;

	localparam int NUM_PIX    = 16;
	localparam int HALF_PIX   = 8;
	localparam int PIX_W      = 8;
	localparam int NUM_GRP    = 4;
	localparam int NUM_PAL    = 4;
	localparam int IDX_W      = 2;
	localparam int EP_W       = 16;
	localparam int SUM_W      = PIX_W + 2;
	localparam int PROD_W     = 2 * SUM_W;
	// floor(x / 3) equals (x * 683) >> 11 for every x up to 3 * 255.
	localparam int DIV3_SHIFT = 11;
	localparam logic [SUM_W-1:0] DIV3_MUL  = SUM_W'(683);
	localparam logic [4:0]       BLUE_MAX  = 5'd31;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [NUM_PAL-1:0][PIX_W-1:0] pal_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [EP_W-1:0] ep_t;

	typedef struct packed {
		logic [63:0] pixels_first_half;
		logic [63:0] pixels_second_half;
	} blk_t;

	typedef struct packed {
		logic [15:0] endpoint_max;
		logic [15:0] endpoint_min;
		logic [31:0] index_word;
	} code_t;

	function automatic ep_t grey_to_565(input pix_t v);
		grey_to_565 = {v[7:3], v[7:2], v[7:3]};
	endfunction

	function automatic pix_t pix_min(input pix_t a, input pix_t b);
		pix_min = (a < b) ? a : b;
	endfunction

	function automatic pix_t pix_max(input pix_t a, input pix_t b);
		pix_max = (a > b) ? a : b;
	endfunction

endpackage

### design/gbce_idx_sel.sv
// Nearest palette entry for one pixel; a tie keeps the lower index.
module gbce_idx_sel (
	input  gbce_pkg::pix_t px,
	input  gbce_pkg::pal_t pal,
	output gbce_pkg::idx_t idx
);

	gbce_pkg::pix_t diff [gbce_pkg::NUM_PAL];

	always_comb begin
		for (int k = 0; k < gbce_pkg::NUM_PAL; k++) begin
			diff[k] = (px > pal[k]) ? px - pal[k] : pal[k] - px;
		end
	end

	always_comb begin
		gbce_pkg::pix_t best_d;
		best_d = diff[0];
		idx    = '0;
		for (int k = 1; k < gbce_pkg::NUM_PAL; k++) begin
			if (diff[k] < best_d) begin
				best_d = diff[k];
				idx    = gbce_pkg::IDX_W'(k);
			end
		end
	end

endmodule

### design/gray_block_cmpr_encoder.sv
// A block passes four pipeline stages, the last of them the output register.
// Throughput: one block per cycle while code_ready is high; a stalled code word
// holds and the stall spreads back through full stages only; nothing is lost.
// Reset: arst_n clears the valid bit of every stage at once; data registers
// are not reset.
`include "gray_block_cmpr_encoder_defines.svh"

module gray_block_cmpr_encoder (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pix_valid,
	output logic            pix_ready,
	input  gbce_pkg::blk_t  pix,
	output logic            code_valid,
	input  logic            code_ready,
	output gbce_pkg::code_t code
);

	// Stage enables.
	logic en_s1, en_s2, en_s3, en_s4;

	logic v_s1, v_s2, v_s3, v_s4;

	gbce_pkg::pix_t px_in  [gbce_pkg::NUM_PIX];
	gbce_pkg::pix_t gmin   [gbce_pkg::NUM_GRP];
	gbce_pkg::pix_t gmax   [gbce_pkg::NUM_GRP];

	gbce_pkg::pix_t px_s1  [gbce_pkg::NUM_PIX];
	gbce_pkg::pix_t gmin_s1[gbce_pkg::NUM_GRP];
	gbce_pkg::pix_t gmax_s1[gbce_pkg::NUM_GRP];

	gbce_pkg::pix_t px_s2  [gbce_pkg::NUM_PIX];
	gbce_pkg::pix_t hi_s2, lo_s2;
	gbce_pkg::pix_t hi_d, lo_d;

	gbce_pkg::pix_t px_s3  [gbce_pkg::NUM_PIX];
	gbce_pkg::ep_t  e0_s3, e1_s3;
	gbce_pkg::pal_t pal_s3;
	gbce_pkg::pix_t hi_s3, lo_s3;

	gbce_pkg::ep_t  e0_d, e1_d;
	gbce_pkg::ep_t  e0_raw, e1_raw;
	gbce_pkg::pal_t pal_d;
	logic [gbce_pkg::SUM_W-1:0]  sum_hi2, sum_lo2;
	logic [gbce_pkg::PROD_W-1:0] prod_hi2, prod_lo2;

	gbce_pkg::idx_t idx_d  [gbce_pkg::NUM_PIX];
	logic [31:0]    word_d;

	gbce_pkg::code_t code_s4;

	assign en_s4     = !v_s4 || code_ready;
	assign en_s3     = !v_s3 || en_s4;
	assign en_s2     = !v_s2 || en_s3;
	assign en_s1     = !v_s1 || en_s2;
	assign pix_ready = en_s1;

	// Unpack the block: pixel 0 sits in the top byte of the first half.
	always_comb begin
		for (int i = 0; i < gbce_pkg::HALF_PIX; i++) begin
			px_in[i] = pix.pixels_first_half[63 - gbce_pkg::PIX_W * i -: gbce_pkg::PIX_W];
			px_in[i + gbce_pkg::HALF_PIX] =
				pix.pixels_second_half[63 - gbce_pkg::PIX_W * i -: gbce_pkg::PIX_W];
		end
	end

	// First half of the min/max tree: one result per group of four pixels.
	always_comb begin
		for (int g = 0; g < gbce_pkg::NUM_GRP; g++) begin
			gmin[g] = gbce_pkg::pix_min(
				gbce_pkg::pix_min(px_in[4*g], px_in[4*g+1]),
				gbce_pkg::pix_min(px_in[4*g+2], px_in[4*g+3]));
			gmax[g] = gbce_pkg::pix_max(
				gbce_pkg::pix_max(px_in[4*g], px_in[4*g+1]),
				gbce_pkg::pix_max(px_in[4*g+2], px_in[4*g+3]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && pix_valid) begin
			px_s1   <= px_in;
			gmin_s1 <= gmin;
			gmax_s1 <= gmax;
		end
	end

	// Second half of the tree.
	assign lo_d = gbce_pkg::pix_min(gbce_pkg::pix_min(gmin_s1[0], gmin_s1[1]),
		gbce_pkg::pix_min(gmin_s1[2], gmin_s1[3]));
	assign hi_d = gbce_pkg::pix_max(gbce_pkg::pix_max(gmax_s1[0], gmax_s1[1]),
		gbce_pkg::pix_max(gmax_s1[2], gmax_s1[3]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			px_s2 <= px_s1;
			hi_s2 <= hi_d;
			lo_s2 <= lo_d;
		end
	end

	// Endpoints and palette. When the two endpoints collide on a block that is
	// not flat, bump blue of the first, or drop the second when blue is full.
	assign e0_raw = gbce_pkg::grey_to_565(hi_s2);
	assign e1_raw = gbce_pkg::grey_to_565(lo_s2);

	always_comb begin
		e0_d = e0_raw;
		e1_d = e1_raw;
		if (hi_s2 > lo_s2 && e0_raw == e1_raw) begin
			if (e0_raw[4:0] < gbce_pkg::BLUE_MAX) begin
				e0_d = e0_raw + gbce_pkg::EP_W'(1);
			end else begin
				e1_d = e1_raw - gbce_pkg::EP_W'(1);
			end
		end
	end

	assign sum_hi2  = {1'b0, hi_s2, 1'b0} + gbce_pkg::SUM_W'(lo_s2);
	assign sum_lo2  = {1'b0, lo_s2, 1'b0} + gbce_pkg::SUM_W'(hi_s2);
	assign prod_hi2 = gbce_pkg::PROD_W'(sum_hi2) * gbce_pkg::PROD_W'(gbce_pkg::DIV3_MUL);
	assign prod_lo2 = gbce_pkg::PROD_W'(sum_lo2) * gbce_pkg::PROD_W'(gbce_pkg::DIV3_MUL);

	assign pal_d[0] = hi_s2;
	assign pal_d[1] = lo_s2;
	assign pal_d[2] = prod_hi2[gbce_pkg::DIV3_SHIFT +: gbce_pkg::PIX_W];
	assign pal_d[3] = prod_lo2[gbce_pkg::DIV3_SHIFT +: gbce_pkg::PIX_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && v_s2) begin
			px_s3  <= px_s2;
			e0_s3  <= e0_d;
			e1_s3  <= e1_d;
			pal_s3 <= pal_d;
			hi_s3  <= hi_s2;
			lo_s3  <= lo_s2;
		end
	end

	// A flat block has four equal palette entries, so every pixel picks zero.
	for (genvar i = 0; i < gbce_pkg::NUM_PIX; i++) begin : g_idx
		gbce_idx_sel u_idx_sel (
			.px  (px_s3[i]),
			.pal (pal_s3),
			.idx (idx_d[i])
		);
		assign word_d[31 - gbce_pkg::IDX_W * i -: gbce_pkg::IDX_W] = idx_d[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en_s4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4 && v_s3) begin
			code_s4.endpoint_max <= e0_s3;
			code_s4.endpoint_min <= e1_s3;
			code_s4.index_word   <= word_d;
		end
	end

	assign code_valid = v_s4;
	assign code       = code_s4;

	`GBCE_ASSERT_SAME(a_order_ok, v_s3, hi_s3 >= lo_s3, "max below min in stage 3")
	`GBCE_ASSERT_SAME(a_ep_order, code_valid, code.endpoint_max >= code.endpoint_min,
		"endpoint order broken")
	`GBCE_ASSERT_SAME(a_ep_distinct, code_valid && code.index_word != 32'd0,
		code.endpoint_max != code.endpoint_min, "indices set with equal endpoints")
	`GBCE_ASSERT_SAME(a_ready_empty, !code_valid, pix_ready, "not ready with empty output")
	`GBCE_ASSERT_NEXT(a_adv_s2, v_s1 && en_s2, v_s2, "item lost between stage 1 and 2")

endmodule

### test/tb_top.sv
// Self-checking testbench for the grey 4x4 block compression encoder.
`timescale 1ns / 100ps

module tb_top;

	localparam int N_DIRECTED  = 17;
	localparam int N_RANDOM    = 880;
	localparam int N_TOTAL     = N_DIRECTED + N_RANDOM;
	localparam int QUIET_FROM  = N_TOTAL - 120;
	localparam int HOLD_AT     = 400;
	localparam int HOLD_CYCLES = 40;
	localparam int DRAIN_AT    = 450;
	localparam int TAIL_CYCLES = 10;
	localparam int MAX_REPORTS = 10;
	localparam int TIMEOUT_NS  = 500_000;

	// One row of the directed plan; the code word is used only when has_want is set.
	typedef struct packed {
		gbce_pkg::blk_t  blk;
		logic            has_want;
		gbce_pkg::code_t want;
	} plan_row_t;

	localparam plan_row_t PLAN [N_DIRECTED] = '{
		'{'{64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000}, 1'b1,
			'{16'h0000, 16'h0000, 32'h0000_0000}},
		'{'{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b1,
			'{16'hFFFF, 16'hFFFF, 32'h0000_0000}},
		'{'{64'hFF00_0000_0000_0000, 64'h0000_0000_0000_0000}, 1'b1,
			'{16'hFFFF, 16'h0000, 32'h1555_5555}},
		'{'{64'h0000_0000_0000_0000, 64'h0000_0000_0000_00FF}, 1'b1,
			'{16'hFFFF, 16'h0000, 32'h5555_5554}},
		'{'{64'h00FF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b1,
			'{16'hFFFF, 16'h0000, 32'h4000_0000}},
		'{'{64'h00FF_00FF_00FF_00FF, 64'h00FF_00FF_00FF_00FF}, 1'b1,
			'{16'hFFFF, 16'h0000, 32'h4444_4444}},
		// Endpoints collide with blue below the top: the max endpoint steps up.
		'{'{64'h0001_0001_0001_0001, 64'h0001_0001_0001_0001}, 1'b1,
			'{16'h0001, 16'h0000, 32'h4444_4444}},
		// Endpoints collide with blue at the top: the min endpoint steps down.
		'{'{64'hFEFF_FEFF_FEFF_FEFF, 64'hFEFF_FEFF_FEFF_FEFF}, 1'b1,
			'{16'hFFFF, 16'hFFFE, 32'h4444_4444}},
		// Range 0..5 puts several pixels halfway between two palette entries.
		'{'{64'h0001_0203_0405_0005, 64'h0500_0204_0103_0500}, 1'b0, '0},
		'{'{64'h0011_2233_4455_6677, 64'h8899_AABB_CCDD_EEFF}, 1'b0, '0},
		'{'{64'hFFEE_DDCC_BBAA_9988, 64'h7766_5544_3322_1100}, 1'b0, '0},
		'{'{64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA}, 1'b0, '0},
		'{'{64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555}, 1'b0, '0},
		'{'{64'h0405_0607_0706_0504, 64'h0405_0607_0706_0504}, 1'b0, '0},
		'{'{64'hFCFD_FEFF_FFFE_FDFC, 64'hFCFC_FFFF_FDFD_FEFE}, 1'b0, '0},
		'{'{64'h8080_8080_8080_8080, 64'h8080_8080_8080_8080}, 1'b1,
			'{16'h8410, 16'h8410, 32'h0000_0000}},
		'{'{64'h00FE_0155_AAFD_7F80, 64'h0203_FEFE_0000_5556}, 1'b0, '0}
	};

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            pix_valid = 1'b0;
	logic            pix_ready;
	gbce_pkg::blk_t  pix = '0;
	logic            code_valid;
	logic            code_ready = 1'b0;
	gbce_pkg::code_t code;

	// Travels with pix: a hand-written code word for the current item, if any.
	logic            pix_has_want = 1'b0;
	gbce_pkg::code_t pix_want = '0;

	gbce_pkg::code_t pending_codes [$];
	int    blocks_accepted = 0;
	int    codes_checked = 0;
	int    flat_blocks = 0;
	int    input_stalls = 0;
	int    mismatches = 0;
	bit    rx_holding = 1'b0;

	gray_block_cmpr_encoder u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_valid  (pix_valid),
		.pix_ready  (pix_ready),
		.pix        (pix),
		.code_valid (code_valid),
		.code_ready (code_ready),
		.code       (code)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic gbce_pkg::ep_t grey_endpoint(input int v);
		return gbce_pkg::ep_t'(((v >> 3) << 11) | ((v >> 2) << 5) | (v >> 3));
	endfunction

	function automatic gbce_pkg::code_t encode_grey_block(input gbce_pkg::blk_t b);
		int    px [gbce_pkg::NUM_PIX];
		int    pal [gbce_pkg::NUM_PAL];
		int    lo, hi, i, k, best, bd, d;
		gbce_pkg::ep_t   e0, e1;
		gbce_pkg::code_t r;
		lo = 255;
		hi = 0;
		r = '0;
		for (i = 0; i < 8; i++) begin
			px[i]     = int'(b.pixels_first_half[63 - 8 * i -: 8]);
			px[i + 8] = int'(b.pixels_second_half[63 - 8 * i -: 8]);
		end
		for (i = 0; i < gbce_pkg::NUM_PIX; i++) begin
			if (px[i] < lo) lo = px[i];
			if (px[i] > hi) hi = px[i];
		end
		e0 = grey_endpoint(hi);
		e1 = grey_endpoint(lo);
		if (hi > lo) begin
			// Keep the endpoints distinct so the block stays in four-color mode.
			if (e0 == e1) begin
				if (e0[4:0] != 5'h1F) e0 = e0 + gbce_pkg::ep_t'(1);
				else e1 = e1 - gbce_pkg::ep_t'(1);
			end
			pal[0] = hi;
			pal[1] = lo;
			pal[2] = (2 * hi + lo) / 3;
			pal[3] = (hi + 2 * lo) / 3;
			for (i = 0; i < gbce_pkg::NUM_PIX; i++) begin
				best = 0;
				bd = (px[i] > pal[0]) ? px[i] - pal[0] : pal[0] - px[i];
				for (k = 1; k < gbce_pkg::NUM_PAL; k++) begin
					d = (px[i] > pal[k]) ? px[i] - pal[k] : pal[k] - px[i];
					if (d < bd) begin
						bd = d;
						best = k;
					end
				end
				r.index_word[31 - 2 * i -: 2] = best[1:0];
			end
		end
		r.endpoint_max = e0;
		r.endpoint_min = e1;
		return r;
	endfunction

	// Random blocks of several shapes: full range, narrow range, one endpoint
	// bucket, flat, two levels, and mixes of the extremes.
	function automatic gbce_pkg::blk_t make_block();
		gbce_pkg::pix_t p [gbce_pkg::NUM_PIX];
		int   kind, lo, hi, a, b, i;
		gbce_pkg::blk_t blk;
		kind = $urandom_range(0, 9);
		lo = 0;
		hi = 255;
		a = $urandom_range(0, 255);
		b = $urandom_range(0, 255);
		case (kind)
			3, 4: begin
				lo = a;
				hi = a + $urandom_range(1, 12);
				if (hi > 255) hi = 255;
			end
			5: begin
				lo = 4 * $urandom_range(0, 63);
				hi = lo + 3;
			end
			6: begin
				lo = a;
				hi = a;
			end
			9: begin
				lo = 252;
				hi = 255;
			end
			default: ;
		endcase
		for (i = 0; i < gbce_pkg::NUM_PIX; i++) begin
			case (kind)
				7: p[i] = $urandom_range(0, 1) ? gbce_pkg::pix_t'(a) : gbce_pkg::pix_t'(b);
				8: begin
					case ($urandom_range(0, 2))
						0: p[i] = 8'h00;
						1: p[i] = 8'hFF;
						default: p[i] = gbce_pkg::pix_t'($urandom_range(0, 255));
					endcase
				end
				default: p[i] = gbce_pkg::pix_t'($urandom_range(hi, lo));
			endcase
		end
		for (i = 0; i < 8; i++) begin
			blk.pixels_first_half[63 - 8 * i -: 8]  = p[i];
			blk.pixels_second_half[63 - 8 * i -: 8] = p[i + 8];
		end
		return blk;
	endfunction

	// Called at a falling edge; returns at the rising edge where the item is taken.
	task automatic send_block(input gbce_pkg::blk_t b, input logic has_want,
		input gbce_pkg::code_t want);
		pix_valid    <= 1'b1;
		pix          <= b;
		pix_has_want <= has_want;
		pix_want     <= want;
		@(posedge clk);
		while (!pix_ready) @(posedge clk);
	endtask

	// Called at the rising edge of an acceptance; returns at a falling edge.
	task automatic pace_sender(input bit allow_gap);
		int gap;
		gap = 0;
		if (allow_gap && !rx_holding && $urandom_range(0, 4) == 0)
			gap = $urandom_range(1, 3);
		@(negedge clk);
		if (gap > 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic wait_for_drain();
		pix_valid <= 1'b0;
		while (pending_codes.size() != 0) @(negedge clk);
	endtask

	// Receiver: short random stalls, one long hold-off, and none near the end.
	initial begin
		int stall_left;
		bit hold_done;
		stall_left = 0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (!arst_n) begin
				code_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				code_ready <= 1'b0;
			end else if (!hold_done && blocks_accepted >= HOLD_AT) begin
				hold_done = 1'b1;
				rx_holding = 1'b1;
				stall_left = HOLD_CYCLES - 1;
				code_ready <= 1'b0;
			end else begin
				rx_holding = 1'b0;
				if (blocks_accepted < QUIET_FROM && $urandom_range(0, 5) == 0) begin
					stall_left = $urandom_range(0, 2);
					code_ready <= 1'b0;
				end else begin
					code_ready <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin : scoreboard
		gbce_pkg::code_t want;
		if (arst_n) begin
			if (pix_valid && pix_ready) begin
				pending_codes.push_back(pix_has_want ? pix_want : encode_grey_block(pix));
				blocks_accepted++;
			end
			if (pix_valid && !pix_ready) input_stalls++;
			if (code_valid && code_ready) begin
				if (pending_codes.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("unexpected code word %h/%h/%h", code.endpoint_max,
							code.endpoint_min, code.index_word);
				end else begin
					want = pending_codes.pop_front();
					if (want.endpoint_max == want.endpoint_min) flat_blocks++;
					if (code.endpoint_max !== want.endpoint_max ||
						code.endpoint_min !== want.endpoint_min ||
						code.index_word !== want.index_word) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("code word %0d: expected %h/%h/%h, got %h/%h/%h",
								codes_checked, want.endpoint_max, want.endpoint_min,
								want.index_word, code.endpoint_max, code.endpoint_min,
								code.index_word);
					end
					codes_checked++;
				end
			end
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		int r, n;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (r = 0; r < N_DIRECTED; r++) begin
			send_block(PLAN[r].blk, PLAN[r].has_want, PLAN[r].want);
			pace_sender(1'b1);
		end
		// Let the pipeline run empty once before the random part.
		wait_for_drain();

		for (n = 0; n < N_RANDOM; n++) begin
			if (N_DIRECTED + n == DRAIN_AT) wait_for_drain();
			send_block(make_block(), 1'b0, '0);
			pace_sender(N_DIRECTED + n + 1 < QUIET_FROM);
		end

		wait_for_drain();
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("%0d blocks encoded and checked (%0d directed, %0d flat)",
			codes_checked, N_DIRECTED, flat_blocks);
		$display("input held back on %0d cycles, including a %0d-cycle output hold-off",
			input_stalls, HOLD_CYCLES);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
